// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Property must never hold at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) not (prop)) \
    else $error("forbidden condition seen");

`endif

// ===== src/msta_pkg.sv =====
// Package with shared widths, register indexes and control structs of the averager.
`default_nettype none

package msta_pkg;

  localparam int unsigned TAPS        = 8;
  localparam int unsigned MAX_SENSORS = 16;

  localparam int unsigned SampleW  = 12;
  localparam int unsigned SumW     = 16;
  localparam int unsigned CountW   = 5;
  localparam int unsigned VrefW    = 13;
  localparam int unsigned TempW    = 16;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW  = 1;

  localparam int unsigned SlotW  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned TotalW = TempW + SlotW;
  localparam int unsigned ProdW  = SumW + VrefW;
  localparam int unsigned NumW   = ProdW + 4;
  localparam int unsigned DenW   = SampleW + CountW;
  localparam int unsigned StepW  = $clog2(TempW);

  localparam logic [CfgIdxW-1:0] RegSensorCount    = 1'b0;
  localparam logic [CfgIdxW-1:0] RegVrefMillivolts = 1'b1;

  localparam logic [CountW-1:0] SensorCountReset = 5'd1;
  localparam logic [VrefW-1:0]  VrefReset        = 13'd3300;
  localparam logic [CountW-1:0] MaxSensors       = CountW'(MAX_SENSORS);

  typedef struct packed {
    logic accumulate;
    logic multiply;
    logic scale;
    logic setup;
    logic divide;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_done;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/multi_sensor_temperature_average_filter.sv =====
// Samples that do not end a scan are accumulated as they are taken; samples may come back to back.
// The beat that ends a scan starts the result sequence: multiply, scale, saturation check,
// then a 16-step restoring divider (one quotient bit a cycle) and the history update, which waits
// for a free output register. No new sample is taken until that sequence has ended.
// Reset clears scan state, the history line and its running total at once (no clearing pass),
// and returns the sensor count register to 1 and the reference register to 3300 mV.
`default_nettype none

module multi_sensor_temperature_average_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [msta_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [msta_pkg::CfgDataW-1:0]   cfg_data_i,
  // Sample input channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [msta_pkg::SampleW-1:0]    adc_sample_i,
  // Result output channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [msta_pkg::TempW-1:0]      scan_average_temp_o,
  output logic [msta_pkg::TempW-1:0]      filtered_temp_o
);
  import msta_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller accepts a sample beat only while idle. A completed scan walks the
  // arithmetic sequence and then waits for the output register to be free before it
  // updates the history line, so a result beat that is still waiting never blocks the
  // samples of the following scan.
  msta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the configuration registers, the scan sum, the divider and the
  // moving-average history line together with its running total.
  msta_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .adc_sample_i        (adc_sample_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .scan_average_temp_o (scan_average_temp_o),
    .filtered_temp_o     (filtered_temp_o)
  );

endmodule

`default_nettype wire

// ===== src/msta_datapath.sv =====
// Datapath: scan accumulator, scaling multiplier, restoring divider and history line.
`default_nettype none

module msta_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [msta_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [msta_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [msta_pkg::SampleW-1:0]    adc_sample_i,
  input  msta_pkg::dp_cmd_t               cmd_i,
  output msta_pkg::dp_status_t            status_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [msta_pkg::TempW-1:0]      scan_average_temp_o,
  output logic [msta_pkg::TempW-1:0]      filtered_temp_o
);
  import msta_pkg::*;

  logic [CountW-1:0] count_q;
  logic [VrefW-1:0]  vref_q;
  logic [SumW-1:0]   sum_q;
  logic [CountW-1:0] pos_q;
  logic [TempW-1:0]  line_q [TAPS];
  logic [SlotW-1:0]  slot_q;
  logic [TotalW-1:0] total_q;
  logic              out_valid_q;

  logic [ProdW-1:0]  prod_q;
  logic [NumW-1:0]   num_q;
  logic [DenW-1:0]   den_q;
  logic [NumW-1:0]   rem_q;
  logic [NumW-1:0]   dsh_q;
  logic [TempW-1:0]  quo_q;
  logic [StepW-1:0]  step_q;
  logic              sat_q;
  logic [TempW-1:0]  scan_avg_q;
  logic [TempW-1:0]  filt_q;

  logic [CountW-1:0] count_lim;
  logic [CountW-1:0] taken;
  logic [TempW-1:0]  scan_value;
  logic [TotalW-1:0] total_d;
  logic [SlotW-1:0]  slot_d;

  assign count_lim  = (count_q > MaxSensors) ? MaxSensors : count_q;
  assign taken      = pos_q + CountW'(1);
  assign scan_value = sat_q ? '1 : quo_q;
  assign total_d    = total_q - TotalW'(line_q[slot_q]) + TotalW'(scan_value);
  assign slot_d     = (slot_q == SlotW'(TAPS - 1)) ? '0 : slot_q + SlotW'(1);

  assign status_o.count_zero = (count_lim == '0);
  assign status_o.scan_done  = (taken >= count_lim);
  assign status_o.div_last   = (step_q == '0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign scan_average_temp_o = scan_avg_q;
  assign filtered_temp_o     = filt_q;

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= SensorCountReset;
      vref_q      <= VrefReset;
      sum_q       <= '0;
      pos_q       <= '0;
      slot_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        line_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == RegSensorCount) begin
          count_q <= cfg_data_i[CountW-1:0];
        end else if (cfg_index_i == RegVrefMillivolts) begin
          vref_q <= cfg_data_i[VrefW-1:0];
        end
      end
      if (cmd_i.accumulate) begin
        sum_q <= sum_q + SumW'(adc_sample_i);
        pos_q <= (taken >= count_lim) ? '0 : taken;
      end
      if (cmd_i.multiply) begin
        sum_q <= '0;
      end
      if (cmd_i.push) begin
        line_q[slot_q] <= scan_value;
        slot_q         <= slot_d;
        total_q        <= total_d;
        out_valid_q    <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Arithmetic pipeline and output data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accumulate) begin
      den_q <= DenW'({taken, {SampleW{1'b0}}}) - DenW'(taken);
    end
    if (cmd_i.multiply) begin
      prod_q <= ProdW'(sum_q) * ProdW'(vref_q);
    end
    if (cmd_i.scale) begin
      num_q <= (NumW'(prod_q) << 3) + (NumW'(prod_q) << 1);
    end
    if (cmd_i.setup) begin
      sat_q  <= (num_q >= NumW'({den_q, {TempW{1'b0}}}));
      rem_q  <= num_q;
      dsh_q  <= NumW'({den_q, {(TempW - 1){1'b0}}});
      quo_q  <= '0;
      step_q <= StepW'(TempW - 1);
    end
    if (cmd_i.divide) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[TempW-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[TempW-2:0], 1'b0};
      end
      dsh_q  <= dsh_q >> 1;
      step_q <= step_q - StepW'(1);
    end
    if (cmd_i.push) begin
      scan_avg_q <= scan_value;
      filt_q     <= TempW'(total_d / TAPS);
    end
  end

endmodule

`default_nettype wire

// ===== src/msta_ctrl.sv =====
// Controller: sequences accumulation, scaling, division and history update.
`default_nettype none

module msta_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  msta_pkg::dp_status_t  status_i,
  output msta_pkg::dp_cmd_t     cmd_o
);
  import msta_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SCALE,
    S_SETUP,
    S_DIV,
    S_PUSH
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accumulate = in_valid_i && in_ready_q && !status_i.count_zero;
        if (cmd_o.accumulate && status_i.scan_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.multiply = 1'b1;
        state_d        = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_SETUP;
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.divide = 1'b1;
        if (status_i.div_last) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

`default_nettype wire

// ===== src/msta_checker.sv =====
// Port-level checker for the averager and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module msta_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [msta_pkg::TempW-1:0]      scan_average_temp_o,
  input logic [msta_pkg::TempW-1:0]      filtered_temp_o
);

  // A waiting result beat holds its data.
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(scan_average_temp_o) && $stable(filtered_temp_o))

  // A new result only appears after the block has been busy computing it.
  `ASSERT_CLK(a_result_after_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(!in_ready_o, 1) && $past(!in_ready_o, 2))

  // The block only goes busy right after taking a sample beat.
  `ASSERT_CLK(a_busy_after_beat, clk_i, rst_ni, $fell(in_ready_o) |-> $past(in_valid_i))

endmodule

bind multi_sensor_temperature_average_filter msta_checker u_msta_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the multi-sensor temperature averager with moving-average smoothing.
`timescale 1ns / 1ps

module tb;
  import msta_pkg::*;

  // Cycles to let pass before a register write, so a scan end still in the divider can drain.
  localparam int unsigned DrainCycles = 24;
  // Cycles without any accepted beat after which the run is declared hung.
  localparam int unsigned StallLimit  = 2000;
  // Random beats per idling mix; the directed table adds the rest.
  localparam int unsigned BeatsPerMix = 611;
  localparam int unsigned AdcFullScale = 4095;
  localparam int unsigned TempScale    = 10;
  localparam int unsigned TempMax      = 65535;
  localparam int unsigned DirectedRows = 17;

  typedef longint unsigned u64_t;

  // One scan result: the raw scan temperature and the smoothed one.
  typedef struct packed {
    logic [TempW-1:0] scan;
    logic [TempW-1:0] filt;
  } temp_pair_t;

  // One row of the directed table: an optional register write, then an optional sample beat.
  // Where typed is set, the expected temperatures are written into the row by hand.
  typedef struct packed {
    logic                do_cfg;
    logic [CfgIdxW-1:0]  reg_index;
    logic [CfgDataW-1:0] reg_data;
    logic                send;
    logic [SampleW-1:0]  sample;
    logic                typed;
    logic [TempW-1:0]    scan;
    logic [TempW-1:0]    filt;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [SampleW-1:0]  adc_sample_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [TempW-1:0]    scan_average_temp_o;
  logic [TempW-1:0]    filtered_temp_o;

  multi_sensor_temperature_average_filter dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .adc_sample_i        (adc_sample_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .scan_average_temp_o (scan_average_temp_o),
    .filtered_temp_o     (filtered_temp_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the block: configuration, scan accumulator and the smoothing history.
  logic [CountW-1:0] cfg_count = SensorCountReset;
  logic [VrefW-1:0]  cfg_vref  = VrefReset;
  logic [SumW-1:0]   acc_sum   = '0;
  logic [CountW-1:0] acc_pos   = '0;
  logic [TempW-1:0]  hist_line [TAPS];
  logic [TotalW-1:0] hist_total = '0;
  int unsigned       hist_slot  = 0;

  temp_pair_t pending_temps [$];

  int unsigned snd_idle_pct  = 16;
  int unsigned rcv_stall_pct = 58;
  int unsigned errors        = 0;
  int unsigned beats_sent    = 0;
  int unsigned scans_checked = 0;
  int unsigned cfg_writes    = 0;
  int unsigned quiet_cycles  = 0;

  initial begin
    foreach (hist_line[k]) hist_line[k] = '0;
  end

  // Folds one accepted sample into the shadow state. Returns 1 when the sample closes a scan,
  // with the scan temperature and the new moving average.
  function automatic logic scan_temperature(input logic [SampleW-1:0] sample,
                                            output logic [TempW-1:0] scan_t,
                                            output logic [TempW-1:0] filt_t);
    logic [CountW-1:0] length;
    logic [CountW:0]   taken;
    u64_t              quotient;
    scan_t = '0;
    filt_t = '0;
    // Counts above the sensor limit behave as the limit; a count of zero ignores samples.
    length = (cfg_count > MaxSensors) ? MaxSensors : cfg_count;
    if (length == '0) return 1'b0;
    acc_sum = acc_sum + SumW'(sample);
    taken = acc_pos + 1'b1;
    // A count lowered mid-scan closes the scan as soon as the sample count reaches or passes it.
    if (taken < length) begin
      acc_pos = CountW'(taken);
      return 1'b0;
    end
    quotient = (u64_t'(acc_sum) * u64_t'(cfg_vref) * TempScale) /
               (u64_t'(AdcFullScale) * u64_t'(taken));
    // A reference beyond its range can push the scan value past 16 bits; it saturates.
    scan_t = (quotient > TempMax) ? TempW'(TempMax) : TempW'(quotient);
    hist_total = hist_total - TotalW'(hist_line[hist_slot]) + TotalW'(scan_t);
    hist_line[hist_slot] = scan_t;
    hist_slot = (hist_slot == TAPS - 1) ? 0 : hist_slot + 1;
    filt_t = TempW'(hist_total / TAPS);
    acc_sum = '0;
    acc_pos = '0;
    return 1'b1;
  endfunction

  // Offers one sample beat and holds it until it is taken. Ready is looked at on the falling
  // edge, where it already has the value the next rising edge will see. Valid is left high
  // afterward, so back-to-back beats never lower and raise it in the same step.
  task automatic send_sample(input logic [SampleW-1:0] sample, input logic typed,
                             input logic [TempW-1:0] t_scan, input logic [TempW-1:0] t_filt);
    logic       taken;
    logic       closes;
    temp_pair_t got;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    adc_sample_i <= sample;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
    beats_sent++;
    closes = scan_temperature(sample, got.scan, got.filt);
    if (closes) begin
      if (typed) begin
        got.scan = t_scan;
        got.filt = t_filt;
      end
      pending_temps.push_back(got);
    end
  endtask

  // Writes one register while the block is idle. The sender first stops and waits until every
  // scan already closed has come out, then lets the divider drain before the write.
  task automatic write_register(input logic [CfgIdxW-1:0] index,
                                input logic [CfgDataW-1:0] data);
    in_valid_i <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
    if (index == RegSensorCount) cfg_count = data[CountW-1:0];
    else cfg_vref = data[VrefW-1:0];
  endtask

  // The receiver stalls at random, at the rate of the current idling mix.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // Result checker. A result beat seen on the falling edge is taken at the next rising edge.
  always @(negedge clk_i) begin
    temp_pair_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_temps.size() == 0) begin
        $display("%0t: result with none expected: scan %0d filtered %0d",
                 $time, scan_average_temp_o, filtered_temp_o);
        errors++;
      end else begin
        want = pending_temps.pop_front();
        scans_checked++;
        if (scan_average_temp_o !== want.scan) begin
          $display("%0t: scan_average_temp expected %0d actual %0d",
                   $time, want.scan, scan_average_temp_o);
          errors++;
        end
        if (filtered_temp_o !== want.filt) begin
          $display("%0t: filtered_temp expected %0d actual %0d",
                   $time, want.filt, filtered_temp_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: any accepted beat on either channel counts as progress.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
                 $time, StallLimit, pending_temps.size());
        $display("tb: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    stim_row_t         rows [DirectedRows];
    int unsigned       mix;
    int unsigned       counted;
    int unsigned       seg_len;
    int unsigned       pick;
    logic [CountW-1:0] new_count;
    logic [CfgDataW-1:0] data;
    logic [SampleW-1:0]  sample;

    // At reset the block counts one sensor per scan at 3300 mV, so a full-scale sample
    // reads 33000 and the history line starts from zero.
    rows = '{
      '{1'b0, RegSensorCount,    13'd0,       1'b1, 12'd0,    1'b1, 16'd0,     16'd0},
      '{1'b0, RegSensorCount,    13'd0,       1'b1, 12'd4095, 1'b1, 16'd33000, 16'd4125},
      '{1'b0, RegSensorCount,    13'd0,       1'b1, 12'd4095, 1'b1, 16'd33000, 16'd8250},
      // Top of the reference range.
      '{1'b1, RegVrefMillivolts, 13'd5000,    1'b1, 12'd4095, 1'b1, 16'd50000, 16'd14500},
      // Reference beyond its range: the scan value saturates.
      '{1'b1, RegVrefMillivolts, 13'h1FFF,    1'b1, 12'd4095, 1'b1, 16'd65535, 16'd22691},
      '{1'b1, RegVrefMillivolts, 13'd0,       1'b1, 12'd4095, 1'b1, 16'd0,     16'd22691},
      '{1'b1, RegVrefMillivolts, 13'd3300,    1'b0, 12'd0,    1'b0, 16'd0,     16'd0},
      // Sensor count zero: samples are dropped without a result.
      '{1'b1, RegSensorCount,    13'd0,       1'b1, 12'd4095, 1'b0, 16'd0,     16'd0},
      '{1'b0, RegSensorCount,    13'd0,       1'b1, 12'hAAA,  1'b0, 16'd0,     16'd0},
      // Upper data bits are ignored for the count: this sets three sensors.
      '{1'b1, RegSensorCount,    13'h1FE3,    1'b1, 12'd4095, 1'b0, 16'd0,     16'd0},
      '{1'b0, RegSensorCount,    13'd0,       1'b1, 12'd0,    1'b0, 16'd0,     16'd0},
      // Count lowered mid-scan: the next sample closes the scan over three samples.
      '{1'b1, RegSensorCount,    13'd1,       1'b1, 12'h555,  1'b0, 16'd0,     16'd0},
      '{1'b1, RegSensorCount,    13'd2,       1'b1, 12'd4095, 1'b0, 16'd0,     16'd0},
      '{1'b0, RegSensorCount,    13'd0,       1'b1, 12'd4095, 1'b0, 16'd0,     16'd0},
      '{1'b0, RegSensorCount,    13'd0,       1'b1, 12'd1,    1'b0, 16'd0,     16'd0},
      '{1'b0, RegSensorCount,    13'd0,       1'b1, 12'd2048, 1'b0, 16'd0,     16'd0},
      '{1'b1, RegSensorCount,    13'd1,       1'b1, 12'd4095, 1'b0, 16'd0,     16'd0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      if (rows[r].do_cfg) write_register(rows[r].reg_index, rows[r].reg_data);
      if (rows[r].send) send_sample(rows[r].sample, rows[r].typed, rows[r].scan, rows[r].filt);
    end

    // Random part, in three idling mixes: receiver slow, then sender slow, then neither.
    for (mix = 0; mix < 3; mix++) begin
      snd_idle_pct  = (mix == 0) ? 16 : (mix == 1) ? 58 : 0;
      rcv_stall_pct = (mix == 0) ? 58 : (mix == 1) ? 16 : 0;
      counted = 0;
      while (counted < BeatsPerMix) begin
        // New sensor count; now and then zero, above the sensor limit, or with junk upper bits.
        pick = $urandom_range(99);
        if (pick < 6) new_count = '0;
        else if (pick < 14) new_count = CountW'($urandom_range(17, 31));
        else if (pick < 22) new_count = MaxSensors;
        else new_count = CountW'($urandom_range(1, 15));
        data = CfgDataW'(new_count);
        if ($urandom_range(3) == 0) data[CfgDataW-1:CountW] = (CfgDataW - CountW)'($urandom);
        write_register(RegSensorCount, data);

        if ($urandom_range(1) == 0) begin
          pick = $urandom_range(99);
          if (pick < 8) data = '0;
          else if (pick < 16) data = CfgDataW'(5000);
          else if (pick < 22) data = '1;
          else if (pick < 30) data = CfgDataW'($urandom_range(5001, 8191));
          else data = CfgDataW'($urandom_range(0, 5000));
          write_register(RegVrefMillivolts, data);
        end

        // Dropped samples under a zero count are kept short and do not count toward the mix.
        seg_len = (new_count == '0) ? 3 : $urandom_range(20, 60);
        repeat (seg_len) begin
          pick = $urandom_range(99);
          if (pick < 8) sample = '0;
          else if (pick < 16) sample = '1;
          else sample = SampleW'($urandom);
          send_sample(sample, 1'b0, '0, '0);
        end
        if (new_count != '0) counted += seg_len;
      end
    end

    in_valid_i <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb: %0d sample beats, %0d scan results checked, %0d register writes,",
             beats_sent, scans_checked, cfg_writes);
    $display("tb: counts 0 to 31, references 0 to 8191, three idling mixes");
    if (errors == 0 && pending_temps.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== multi_sensor_temperature_average_filter.f =====
+incdir+src
src/msta_pkg.sv
src/msta_datapath.sv
src/msta_ctrl.sv
src/multi_sensor_temperature_average_filter.sv
src/msta_checker.sv
tb/tb.sv
